[hw/rtl/iirh_pkg.sv]
// iirh_pkg: shared constants for the iir hilbert transformer
// section coefficients, fixed-point widths and sequencer indexes; no dependencies
`default_nettype none

package iirh_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int STATE_BITS_DEF  = 28;

    // internal values carry the sample shifted left by this many bits
    localparam int GUARD_BITS = 3;

    localparam int COEF_FRAC = 18;
    localparam int COEF_BITS = 18;

    localparam int NUM_SECTIONS = 8;
    localparam int SEC_W        = 3;

    // last section of the real cascade and of the imaginary cascade
    localparam logic [SEC_W-1:0] REAL_LAST_SEC = 3'd3;
    localparam logic [SEC_W-1:0] LAST_SEC      = 3'd7;
    localparam logic [SEC_W-1:0] FIRST_SEC     = 3'd0;

    // allpass coefficients c = a^2, 18 fraction bits, real sections then imaginary
    localparam logic [COEF_BITS-1:0] SEC_COEF [NUM_SECTIONS] = '{
        18'd42404,  18'd192159, 18'd247818, 18'd259679,
        18'd125672, 18'd229695, 18'd256010, 18'd261489
    };

endpackage

`default_nettype wire

[hw/rtl/iirh_in_if.sv]
// iirh_in_if: sample channel of the iir hilbert transformer
// valid/ready handshake with one signed sample; uses iirh_pkg for the default width
`default_nettype none

interface iirh_in_if #(
    parameter int SAMPLE_BITS = iirh_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

[hw/rtl/iirh_out_if.sv]
// iirh_out_if: result channel of the iir hilbert transformer
// valid/ready handshake with the quadrature pair; uses iirh_pkg for the default width
`default_nettype none

interface iirh_out_if #(
    parameter int SAMPLE_BITS = iirh_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] real_out;
    logic signed [SAMPLE_BITS-1:0] imag_out;

    modport source (output valid, output real_out, output imag_out, input ready);
    modport sink   (input valid, input real_out, input imag_out, output ready);
endinterface

`default_nettype wire

[hw/rtl/iirh_ram.sv]
// iirh_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module iirh_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/iirh_top.sv]
// iir_hilbert_transformer_top: each accepted sample gives one quadrature pair.
// The real output is the sample through four second-order allpass sections, the
// imaginary output is the previous sample through four more, all in direct form II
// with saturating 28-bit state and rounded 16-bit outputs. One shared multiplier
// serves all eight sections; each section multiplies by w[n-2], adds, multiplies by
// w and adds the output; the section state w[n-1] and w[n-2] sits in two 8-entry
// rams read one section ahead. After its transfer an item passes a start state,
// the eight sections, the handover of the pair to the output register and a return
// to idle, and no new sample is taken before that return. The result waits in an
// output register so the next sample is taken while it is unread; the handover
// stage stalls only while the previous result is still unread. Depends on iirh_pkg,
// iirh_in_if, iirh_out_if and iirh_ram.
`default_nettype none

module iir_hilbert_transformer_top #(
    parameter int SAMPLE_BITS = iirh_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = iirh_pkg::STATE_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    iirh_in_if.sink   sample_ch,
    iirh_out_if.source result_ch
);

    localparam int GUARD  = iirh_pkg::GUARD_BITS;
    localparam int CFRAC  = iirh_pkg::COEF_FRAC;
    localparam int CBITS  = iirh_pkg::COEF_BITS;
    localparam int SEC_W  = iirh_pkg::SEC_W;
    localparam int PROD_W = STATE_BITS + CBITS + 1;
    localparam int RND_W  = PROD_W + 1 - CFRAC;
    localparam int OUT_W  = STATE_BITS + 1 - GUARD;
    localparam int SAT_W  = ((STATE_BITS + 4) > (SAMPLE_BITS + GUARD + 4)) ?
                            (STATE_BITS + 4) : (SAMPLE_BITS + GUARD + 4);

    localparam logic [PROD_W:0] PROD_HALF =
        {{(PROD_W - CFRAC + 1){1'b0}}, 1'b1, {(CFRAC - 1){1'b0}}};
    localparam logic [STATE_BITS:0] OUT_HALF =
        {{(STATE_BITS - GUARD + 1){1'b0}}, 1'b1, {(GUARD - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_ADDW,
        S_MUL2,
        S_ADDY,
        S_DONE
    } state_t;

    function automatic logic [STATE_BITS-1:0] sat_state(input logic [SAT_W-1:0] v);
        logic [SAT_W-STATE_BITS:0] top;
        top = v[SAT_W-1:STATE_BITS-1];
        if (&top || ~|top)
            sat_state = v[STATE_BITS-1:0];
        else if (v[SAT_W-1])
            sat_state = {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            sat_state = {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [SAT_W-1:0] v);
        logic [SAT_W-SAMPLE_BITS:0] top;
        top = v[SAT_W-1:SAMPLE_BITS-1];
        if (&top || ~|top)
            sat_sample = v[SAMPLE_BITS-1:0];
        else if (v[SAT_W-1])
            sat_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    // round(prod / 2^frac), ties up, sign-extended to the working width
    function automatic logic [SAT_W-1:0] round_prod(input logic [PROD_W-1:0] p);
        logic [PROD_W:0]  sum;
        logic [RND_W-1:0] r;
        sum = {p[PROD_W-1], p} + PROD_HALF;
        r = sum[PROD_W:CFRAC];
        round_prod = {{(SAT_W-RND_W){r[RND_W-1]}}, r};
    endfunction

    function automatic logic [SAT_W-1:0] sext_state(input logic [STATE_BITS-1:0] v);
        sext_state = {{(SAT_W-STATE_BITS){v[STATE_BITS-1]}}, v};
    endfunction

    // sample scaled by the guard bits, saturated into the state range
    function automatic logic [STATE_BITS-1:0] in_conv(input logic [SAMPLE_BITS-1:0] s);
        logic [SAT_W-1:0] v;
        v = {{(SAT_W-SAMPLE_BITS-GUARD){s[SAMPLE_BITS-1]}}, s, {GUARD{1'b0}}};
        in_conv = sat_state(v);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] out_conv(input logic [STATE_BITS-1:0] v);
        logic [STATE_BITS:0] sum;
        logic [OUT_W-1:0]    r;
        sum = {v[STATE_BITS-1], v} + OUT_HALF;
        r = sum[STATE_BITS:GUARD];
        out_conv = sat_sample({{(SAT_W-OUT_W){r[OUT_W-1]}}, r});
    endfunction

    state_t                          state_reg;
    logic [SEC_W-1:0]                sec_reg;
    logic [iirh_pkg::NUM_SECTIONS-1:0] sec_valid_reg;
    logic                            rd_valid_reg;
    logic                            out_valid_reg;
    logic [SAMPLE_BITS-1:0]          real_out_reg;
    logic [SAMPLE_BITS-1:0]          imag_out_reg;
    logic [SAMPLE_BITS-1:0]          delayed_reg;

    logic [SAMPLE_BITS-1:0]          cur_reg;
    logic [SAMPLE_BITS-1:0]          real_res_reg;
    logic [STATE_BITS-1:0]           x_reg;
    logic [STATE_BITS-1:0]           w_reg;
    logic [STATE_BITS-1:0]           w1_reg;
    logic [STATE_BITS-1:0]           w2_reg;
    logic signed [PROD_W-1:0]        prod_reg;

    logic                            in_xfer;
    logic                            out_xfer;
    logic                            out_free;
    logic [SEC_W-1:0]                sec_inc;
    logic                            ram_wr_en;
    logic                            ram_rd_en;
    logic [SEC_W-1:0]                ram_rd_addr;
    logic [STATE_BITS-1:0]           ram_a_rdata;
    logic [STATE_BITS-1:0]           ram_b_rdata;
    logic [STATE_BITS-1:0]           w1_rd;
    logic [STATE_BITS-1:0]           w2_rd;
    logic signed [CBITS:0]           mul_coef;
    logic signed [STATE_BITS-1:0]    mul_data;
    logic signed [PROD_W-1:0]        prod_next;
    logic [STATE_BITS-1:0]           w_next;
    logic [STATE_BITS-1:0]           y_next;

    assign in_xfer  = sample_ch.valid && sample_ch.ready;
    assign out_xfer = result_ch.valid && result_ch.ready;
    assign out_free = !out_valid_reg || result_ch.ready;
    assign sec_inc  = sec_reg + SEC_W'(1);

    assign sample_ch.ready    = (state_reg == S_IDLE);
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.real_out = real_out_reg;
    assign result_ch.imag_out = imag_out_reg;

    // w[n-1] in ram a, w[n-2] in ram b, both written back in the second multiply step
    assign ram_wr_en   = (state_reg == S_MUL2);
    assign ram_rd_en   = in_xfer || ((state_reg == S_MUL2) && (sec_reg != iirh_pkg::LAST_SEC));
    assign ram_rd_addr = (state_reg == S_IDLE) ? iirh_pkg::FIRST_SEC : sec_inc;

    iirh_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (iirh_pkg::NUM_SECTIONS)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (sec_reg),
        .wr_data (w_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_a_rdata)
    );

    iirh_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (iirh_pkg::NUM_SECTIONS)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (sec_reg),
        .wr_data (w1_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_b_rdata)
    );

    // a section never written since reset reads as zero
    assign w1_rd = rd_valid_reg ? ram_a_rdata : '0;
    assign w2_rd = rd_valid_reg ? ram_b_rdata : '0;

    always_comb
    begin
        case (state_reg)
            S_MUL2:
            begin
                mul_coef = {1'b0, iirh_pkg::SEC_COEF[sec_reg]};
                mul_data = w_reg;
            end
            S_ADDY:
            begin
                mul_coef = {1'b0, iirh_pkg::SEC_COEF[sec_inc]};
                mul_data = w2_rd;
            end
            default:
            begin
                mul_coef = {1'b0, iirh_pkg::SEC_COEF[sec_reg]};
                mul_data = w2_rd;
            end
        endcase
    end

    assign prod_next = mul_coef * mul_data;
    assign w_next    = sat_state(sext_state(x_reg) + round_prod(prod_reg));
    assign y_next    = sat_state(round_prod(prod_reg) - sext_state(w2_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sec_reg       <= iirh_pkg::FIRST_SEC;
            sec_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            real_out_reg  <= '0;
            imag_out_reg  <= '0;
            delayed_reg   <= '0;
        end
        else
        begin
            if (ram_rd_en)
            begin
                rd_valid_reg <= sec_valid_reg[ram_rd_addr];
            end
            // in the handover stage a new pair replaces the one being taken
            if (out_xfer && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        sec_reg   <= iirh_pkg::FIRST_SEC;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_ADDW;
                end
                S_ADDW:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    sec_valid_reg[sec_reg] <= 1'b1;
                    state_reg              <= S_ADDY;
                end
                S_ADDY:
                begin
                    if (sec_reg == iirh_pkg::REAL_LAST_SEC)
                    begin
                        delayed_reg <= cur_reg;
                    end
                    if (sec_reg == iirh_pkg::LAST_SEC)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sec_reg   <= sec_inc;
                        state_reg <= S_ADDW;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        real_out_reg  <= real_res_reg;
                        imag_out_reg  <= out_conv(x_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cur_reg <= sample_ch.sample_in;
                    x_reg   <= in_conv(sample_ch.sample_in);
                end
            end
            S_MUL1:
            begin
                prod_reg <= prod_next;
                w1_reg   <= w1_rd;
                w2_reg   <= w2_rd;
            end
            S_ADDW:
            begin
                w_reg <= w_next;
            end
            S_MUL2:
            begin
                prod_reg <= prod_next;
            end
            S_ADDY:
            begin
                // first multiply of the next section overlaps the output add
                prod_reg <= prod_next;
                w1_reg   <= w1_rd;
                w2_reg   <= w2_rd;
                if (sec_reg == iirh_pkg::REAL_LAST_SEC)
                begin
                    real_res_reg <= out_conv(y_next);
                    x_reg        <= in_conv(delayed_reg);
                end
                else
                begin
                    x_reg <= y_next;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (sec_reg == iirh_pkg::LAST_SEC))
        else $error("result stage reached before the last section");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en) |-> (ram_rd_addr != sec_reg))
        else $error("section read and write-back hit the same entry");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the result stage");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !sample_ch.ready)
        else $error("sample taken while a pass is running");
`endif

endmodule

`default_nettype wire
